// File: rtl/slip_time_weakening_friction_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the slip/time weakening friction core
// Each macro expects clk and arst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef SLIP_TIME_WEAKENING_FRICTION_CORE_MACROS_SVH
`define SLIP_TIME_WEAKENING_FRICTION_CORE_MACROS_SVH

// same-cycle implication
`define STWF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("stwf: property violated");

// next-cycle implication
`define STWF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("stwf: property violated");

`endif

// File: rtl/stwf_pkg.sv
// ----------------------------------------------------------------------------
// stwf_pkg
// Types and register codes of the slip/time weakening friction core.
// ----------------------------------------------------------------------------
package stwf_pkg;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned STATE_W   = 64;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COEF_STATIC     = 3'd0,
		CFG_COEF_DYNAMIC    = 3'd1,
		CFG_WEAKENING_SLIP  = 3'd2,
		CFG_COHESION        = 3'd3,
		CFG_WEAKENING_START = 3'd4,
		CFG_WEAKENING_SPAN  = 3'd5,
		CFG_RATE_TOLERANCE  = 3'd6
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DIV_SW,
		ST_LOAD_TW,
		ST_DIV_TW,
		ST_MUL_W,
		ST_MU,
		ST_MUL_F,
		ST_FRIC,
		ST_MUL_S,
		ST_LOAD_S,
		ST_DIV_S,
		ST_FIN_S,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		TW_ZERO,
		TW_RAMP,
		TW_FULL
	} tw_zone_t;

endpackage

// File: rtl/stwf_ram.sv
// ----------------------------------------------------------------------------
// stwf_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module stwf_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/slip_time_weakening_friction_core.sv
// ----------------------------------------------------------------------------
// slip_time_weakening_friction_core
// Linear slip/time weakening friction per fault point, state kept in RAM.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    kind point sim_time slip slip_rate
//                                             normal_traction
//  out      source     out_valid / out_stall  friction friction_slope saturated
//  cfg      sink       cfg_valid / cfg_ready  cfg_index cfg_data
//
//  One item at a time: a tension item goes from ST_READ straight to ST_OUT;
//  a compressed item may use the bit-serial divider for up to two weakening
//  fractions, then for the 32-bit slope quotient.
//  After reset a clearing pass writes zero to all POINTS entries, one a
//  cycle; no input beat is taken until it ends.
//  A finished result waits in the output register while the next beat is taken.
// ----------------------------------------------------------------------------
module slip_time_weakening_friction_core import stwf_pkg::*; #(
	parameter int unsigned POINTS    = 1024,
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 kind,
	input  logic [9:0]           point,
	input  logic signed [31:0]   sim_time,
	input  logic signed [31:0]   slip,
	input  logic signed [31:0]   slip_rate,
	input  logic signed [31:0]   normal_traction,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [31:0]   friction,
	output logic signed [31:0]   friction_slope,
	output logic                 saturated,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0]    cfg_data
);

	localparam int unsigned AW = (POINTS > 1) ? $clog2(POINTS) : 1;
	localparam int unsigned WW = FRAC_BITS + 1;
	localparam int unsigned CW = 6;
	localparam logic [CW-1:0] FRAC_CNT = CW'(FRAC_BITS - 1);
	localparam logic [CW-1:0] WORD_CNT = CW'(31);
	localparam logic [WW-1:0] ONE_W    = {1'b1, {FRAC_BITS{1'b0}}};
	localparam logic [16:0]   POINTS_X = 17'(POINTS);
	localparam logic [AW-1:0] LAST_PT  = AW'(POINTS - 1);

	state_t state_q, state_d;

	// configuration
	logic [30:0]        cs_q, cd_q, ws_q, t0_q, span_q, rt_q;
	logic signed [31:0] coh_q;

	// item
	logic               kind_q, inr_q;
	logic [AW-1:0]      addr_q;
	logic signed [31:0] t_q, slip_q, rate_q, nt_q;

	// work registers
	logic               done_q, tension_q, neg_q;
	tw_zone_t           zone_q;
	logic [31:0]        tdiff_q;
	logic [WW-1:0]      sw_q, tw_q;
	logic signed [32:0] mu_q;
	logic signed [65:0] prod_q;
	logic signed [31:0] fric_q, slope_q;
	logic               fsat_q, ssat_q;
	logic [31:0]        div_r_q, div_n_q, div_q_q;
	logic [CW-1:0]      div_cnt_q;
	logic [AW-1:0]      clr_q;
	logic               out_valid_q;
	logic signed [31:0] friction_q, friction_slope_q;
	logic               saturated_q;

	// RAM
	logic               ram_we, ram_re;
	logic [AW-1:0]      ram_waddr, ram_raddr;
	logic [STATE_W-1:0] ram_wdata, ram_rdata;

	logic               accept;
	logic [16:0]        pt_x;

	assign pt_x      = 17'(point);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	stwf_ram #(.WIDTH(STATE_W), .DEPTH(POINTS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---- read stage: slip accumulation and commit ----
	logic [31:0]        cum0;
	logic signed [32:0] prev_x, slip_x, d_x;
	logic [32:0]        absd;
	logic [33:0]        cum;
	logic [31:0]        cum_new;
	logic               sliding, done_c;
	logic signed [33:0] t_x, t0_x, end_x, tdiff_x;

	always_comb begin
		cum0    = inr_q ? ram_rdata[63:32] : 32'd0;
		prev_x  = inr_q ? {ram_rdata[31], ram_rdata[31:0]} : 33'sd0;
		slip_x  = {slip_q[31], slip_q};
		d_x     = slip_x - prev_x;
		absd    = d_x[32] ? 33'(-d_x) : 33'(d_x);
		cum     = {2'b00, cum0} + {1'b0, absd};
		sliding = $signed({rate_q[31], rate_q}) > $signed({2'b00, rt_q});
		if (!sliding) begin
			cum_new = 32'd0;
		end else if (|cum[33:32]) begin
			cum_new = 32'hFFFF_FFFF;
		end else begin
			cum_new = cum[31:0];
		end
		done_c  = cum >= {3'b000, ws_q};
		t_x     = {{2{t_q[31]}}, t_q};
		t0_x    = {3'b000, t0_q};
		end_x   = t0_x + $signed({3'b000, span_q});
		tdiff_x = t_x - t0_x;
	end

	// ---- shared bit-serial divider ----
	logic [30:0] div_d;
	logic [32:0] div_r2, div_sub;
	logic        div_ge;
	logic [31:0] div_r_nx, div_q_nx;

	always_comb begin
		div_d    = (state_q == ST_DIV_TW) ? span_q : ws_q;
		div_r2   = {div_r_q, div_n_q[31]};
		div_sub  = div_r2 - {2'b00, div_d};
		div_ge   = div_r2 >= {2'b00, div_d};
		div_r_nx = div_ge ? div_sub[31:0] : div_r2[31:0];
		div_q_nx = {div_q_q[30:0], div_ge};
	end

	// ---- shared multiplier operands and result arithmetic ----
	logic signed [32:0] diff_x, mul_a, mul_b;
	logic [WW-1:0]      w_c;
	logic               slope_need;
	logic signed [65:0] mu_sh, negp, fric_sh, fric_sum, mag;
	logic [33:0]        mag_hi;
	logic signed [32:0] sq;

	always_comb begin
		diff_x     = $signed({2'b00, cs_q}) - $signed({2'b00, cd_q});
		w_c        = (sw_q > tw_q) ? sw_q : tw_q;
		slope_need = (sw_q > tw_q) && !done_q;
		mu_sh      = prod_q >>> FRAC_BITS;
		negp       = -prod_q;
		fric_sh    = negp >>> FRAC_BITS;
		fric_sum   = fric_sh + 66'(coh_q);
		mag        = prod_q[65] ? negp : prod_q;
		mag_hi     = mag[65:32];
		sq         = neg_q ? -$signed({1'b0, div_q_q}) : $signed({1'b0, div_q_q});
	end

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == LAST_PT) state_d = ST_IDLE;
			ST_IDLE:    if (accept) state_d = ST_READ;
			ST_READ: begin
				if ($signed(nt_q) > 0) begin
					state_d = ST_OUT;
				end else if (!done_c) begin
					state_d = ST_DIV_SW;
				end else begin
					state_d = ST_LOAD_TW;
				end
			end
			ST_DIV_SW:  if (div_cnt_q == '0) state_d = ST_LOAD_TW;
			ST_LOAD_TW: state_d = (zone_q == TW_RAMP) ? ST_DIV_TW : ST_MUL_W;
			ST_DIV_TW:  if (div_cnt_q == '0) state_d = ST_MUL_W;
			ST_MUL_W:   state_d = ST_MU;
			ST_MU:      state_d = ST_MUL_F;
			ST_MUL_F:   state_d = ST_FRIC;
			ST_FRIC:    state_d = slope_need ? ST_MUL_S : ST_OUT;
			ST_MUL_S:   state_d = ST_LOAD_S;
			ST_LOAD_S:  state_d = (mag_hi >= {3'b000, ws_q}) ? ST_OUT : ST_DIV_S;
			ST_DIV_S:   if (div_cnt_q == '0) state_d = ST_FIN_S;
			ST_FIN_S:   state_d = ST_OUT;
			ST_OUT:     if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// ---- outputs of the sequencer ----
	always_comb begin
		in_stall  = (state_q != ST_IDLE);
		ram_re    = accept;
		ram_raddr = pt_x[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = {cum_new, slip_q};
		mul_a     = $signed({nt_q[31], nt_q});
		mul_b     = diff_x;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			ST_READ:  ram_we = kind_q && inr_q;
			ST_MUL_W: begin
				mul_a = diff_x;
				mul_b = $signed(33'(w_c));
			end
			ST_MUL_F: begin
				mul_a = mu_q;
				mul_b = $signed({nt_q[31], nt_q});
			end
			default: ;
		endcase
	end

	// ---- control and configuration registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			cs_q        <= 31'd39322;
			cd_q        <= 31'd32768;
			ws_q        <= 31'd65536;
			coh_q       <= 32'sd0;
			t0_q        <= 31'd0;
			span_q      <= 31'd65536;
			rt_q        <= 31'd0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_COEF_STATIC:     cs_q   <= cfg_data[30:0];
					CFG_COEF_DYNAMIC:    cd_q   <= cfg_data[30:0];
					CFG_WEAKENING_SLIP:  ws_q   <= cfg_data[30:0];
					CFG_COHESION:        coh_q  <= $signed(cfg_data);
					CFG_WEAKENING_START: t0_q   <= cfg_data[30:0];
					CFG_WEAKENING_SPAN:  span_q <= cfg_data[30:0];
					CFG_RATE_TOLERANCE:  rt_q   <= cfg_data[30:0];
					default: ;
				endcase
			end
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (accept) begin
			kind_q <= kind;
			inr_q  <= pt_x < POINTS_X;
			addr_q <= pt_x[AW-1:0];
			t_q    <= sim_time;
			slip_q <= slip;
			rate_q <= slip_rate;
			nt_q   <= normal_traction;
		end
		case (state_q)
			ST_READ: begin
				tension_q <= $signed(nt_q) > 0;
				done_q    <= done_c;
				fric_q    <= 32'sd0;
				slope_q   <= 32'sd0;
				fsat_q    <= 1'b0;
				ssat_q    <= 1'b0;
				sw_q      <= ONE_W;
				tdiff_q   <= tdiff_x[31:0];
				if (t_x < t0_x) begin
					zone_q <= TW_ZERO;
				end else if (t_x < end_x) begin
					zone_q <= TW_RAMP;
				end else begin
					zone_q <= TW_FULL;
				end
				// when the slip division runs, cum is below weakening_slip, so it fits 31 bits
				div_r_q   <= {1'b0, cum[30:0]};
				div_n_q   <= '0;
				div_q_q   <= '0;
				div_cnt_q <= FRAC_CNT;
			end
			ST_DIV_SW, ST_DIV_TW, ST_DIV_S: begin
				div_r_q   <= div_r_nx;
				div_n_q   <= div_n_q << 1;
				div_q_q   <= div_q_nx;
				div_cnt_q <= div_cnt_q - 1'b1;
				if (state_q == ST_DIV_SW) begin
					sw_q <= div_q_nx[WW-1:0];
				end
				if (state_q == ST_DIV_TW) begin
					tw_q <= div_q_nx[WW-1:0];
				end
			end
			ST_LOAD_TW: begin
				tw_q      <= (zone_q == TW_FULL) ? ONE_W : '0;
				div_r_q   <= tdiff_q;
				div_n_q   <= '0;
				div_q_q   <= '0;
				div_cnt_q <= FRAC_CNT;
			end
			ST_MU: mu_q <= $signed({2'b00, cs_q}) - mu_sh[32:0];
			ST_FRIC: begin
				if (fric_sum > 66'sh0_7FFF_FFFF) begin
					fric_q <= 32'sh7FFF_FFFF;
					fsat_q <= 1'b1;
				end else if (fric_sum < -66'sh0_8000_0000) begin
					fric_q <= -32'sh8000_0000;
					fsat_q <= 1'b1;
				end else begin
					fric_q <= fric_sum[31:0];
				end
			end
			ST_LOAD_S: begin
				neg_q     <= prod_q[65];
				div_r_q   <= mag_hi[31:0];
				div_n_q   <= mag[31:0];
				div_q_q   <= '0;
				div_cnt_q <= WORD_CNT;
				// quotient of 2^32 or more: clamp at once
				if (mag_hi >= {3'b000, ws_q}) begin
					slope_q <= prod_q[65] ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
					ssat_q  <= 1'b1;
				end
			end
			ST_FIN_S: begin
				if (sq > 33'sh0_7FFF_FFFF) begin
					slope_q <= 32'sh7FFF_FFFF;
					ssat_q  <= 1'b1;
				end else if (sq < -33'sh0_8000_0000) begin
					slope_q <= -32'sh8000_0000;
					ssat_q  <= 1'b1;
				end else begin
					slope_q <= sq[31:0];
				end
			end
			default: ;
		endcase
		if (state_q == ST_OUT && (!out_valid_q || !out_stall)) begin
			friction_q       <= tension_q ? 32'sd0 : fric_q;
			friction_slope_q <= tension_q ? 32'sd0 : slope_q;
			saturated_q      <= !tension_q && (fsat_q || ssat_q);
		end
	end

	assign out_valid      = out_valid_q;
	assign friction       = friction_q;
	assign friction_slope = friction_slope_q;
	assign saturated      = saturated_q;

endmodule

// File: rtl/stwf_checker.sv
// ----------------------------------------------------------------------------
// stwf_checker
// Port-level checks on the friction core, bound to the top level.
// ----------------------------------------------------------------------------
`include "slip_time_weakening_friction_core_macros.svh"

module stwf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] friction,
	input logic [31:0] friction_slope,
	input logic        saturated
);

	// a stalled result stays offered
	`STWF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid)

	// one item in flight: busy right after a beat
	`STWF_ASSERT_NXT(a_busy_after_beat, in_valid && !in_stall, in_stall)

	// a result only appears after the core has been working
	`STWF_ASSERT_IMP(a_result_after_work, $rose(out_valid), $past(in_stall))

	// the flag means one of the results sits at a rail
	`STWF_ASSERT_IMP(a_sat_at_rail, out_valid && saturated, friction == 32'h7FFF_FFFF || friction == 32'h8000_0000 || friction_slope == 32'h7FFF_FFFF || friction_slope == 32'h8000_0000)

endmodule

bind slip_time_weakening_friction_core stwf_checker u_stwf_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// Slip/time weakening friction core testbench
// Drives fault point beats through a directed table and then random phases,
// each under its own register setting. Every accepted beat is run through a
// local model of the friction law and its per point slip store. Each result
// beat is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb import stwf_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int    NPOINTS    = 1024;
	localparam int    FRAC       = 16;
	localparam longint ONE_FIX   = longint'(1) << FRAC;
	localparam int    LIMIT      = 800000;
	localparam int    PHASES     = 6;
	localparam int    PER_PHASE  = 185;

	typedef struct packed {
		bit        kind;
		bit [9:0]  point;
		int        sim_time;
		int        slip;
		int        slip_rate;
		int        normal_traction;
	} fault_beat_t;

	typedef struct packed {
		int friction;
		int slope;
		bit sat;
	} friction_t;

	typedef struct packed {
		fault_beat_t beat;
		bit          typed;
		friction_t   res;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic kind = 0;
	logic [9:0] point = '0;
	logic signed [31:0] sim_time = '0, slip = '0, slip_rate = '0, normal_traction = '0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] friction, friction_slope;
	logic saturated;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;

	slip_time_weakening_friction_core dut (.*);

	always #5 clk = ~clk;

	// local copy of registers and slip stores
	longint coef_s = 39322, coef_d = 32768, wk_slip = 65536, coh = 0;
	longint wk_start = 0, wk_span = 65536, rate_tol = 0;
	bit [31:0] cum_store [NPOINTS];
	longint    prev_store [NPOINTS];
	int        last_slip [8];

	friction_t pending_q [$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0, stall_pct = 0;

	function automatic int clamp32(longint x, ref bit flag);
		if (x > 64'sd2147483647) begin
			flag = 1;
			return 32'h7fffffff;
		end
		if (x < -64'sd2147483648) begin
			flag = 1;
			return 32'h80000000;
		end
		return int'(x);
	endfunction

	function automatic friction_t predict_friction(fault_beat_t b);
		friction_t r;
		longint d, cum, sw, tw, w, diff, mu, t, nt;
		bit done, flag;
		flag = 0;
		r = '0;
		t = longint'(b.sim_time);
		nt = longint'(b.normal_traction);
		d = longint'(b.slip) - prev_store[b.point];
		cum = longint'(cum_store[b.point]) + (d < 0 ? -d : d);
		if (nt <= 0) begin
			done = cum >= wk_slip;
			sw = done ? ONE_FIX : (cum <<< FRAC) / wk_slip;
			if (t < wk_start)
				tw = 0;
			else if (t < wk_start + wk_span)
				tw = ((t - wk_start) <<< FRAC) / wk_span;
			else
				tw = ONE_FIX;
			w = sw > tw ? sw : tw;
			diff = coef_s - coef_d;
			mu = coef_s - ((diff * w) >>> FRAC);
			r.friction = clamp32(((-(mu * nt)) >>> FRAC) + coh, flag);
			if (sw > tw && !done)
				r.slope = clamp32((nt * diff) / wk_slip, flag);
			r.sat = flag;
		end
		if (b.kind) begin
			if (longint'(b.slip_rate) > rate_tol)
				cum_store[b.point] = cum > 64'hffffffff ? 32'hffffffff : cum[31:0];
			else
				cum_store[b.point] = '0;
			prev_store[b.point] = longint'(b.slip);
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch %s: got %0d, want %0d", field, got, want);
		errors++;
	endtask

	task automatic write_reg(cfg_idx_t idx, bit [31:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 0;
		case (idx)
			CFG_COEF_STATIC:     coef_s = longint'(val[30:0]);
			CFG_COEF_DYNAMIC:    coef_d = longint'(val[30:0]);
			CFG_WEAKENING_SLIP:  wk_slip = longint'(val[30:0]);
			CFG_COHESION:        coh = longint'(signed'(val));
			CFG_WEAKENING_START: wk_start = longint'(val[30:0]);
			CFG_WEAKENING_SPAN:  wk_span = longint'(val[30:0]);
			CFG_RATE_TOLERANCE:  rate_tol = longint'(val[30:0]);
			default: ;
		endcase
	endtask

	// raises in_valid after random idle gaps; holds the beat until taken
	task automatic send_beat(fault_beat_t b, bit typed, friction_t typed_res);
		friction_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		kind <= b.kind;
		point <= b.point;
		sim_time <= b.sim_time;
		slip <= b.slip;
		slip_rate <= b.slip_rate;
		normal_traction <= b.normal_traction;
		do @(negedge clk); while (in_stall);
		r = predict_friction(b);
		pending_q.push_back(typed ? typed_res : r);
		@(posedge clk);
	endtask

	function automatic fault_beat_t random_beat();
		fault_beat_t b;
		int p;
		longint t;
		b.kind = 1'($urandom_range(1));
		if ($urandom_range(99) < 20) begin
			b.point = 10'($urandom);
			b.sim_time = $urandom;
			b.slip = $urandom;
			b.slip_rate = $urandom;
			b.normal_traction = $urandom;
			return b;
		end
		p = $urandom_range(7);
		b.point = 10'(p);
		last_slip[p] += int'($urandom_range(40000)) - 8000;
		b.slip = last_slip[p];
		t = wk_start + longint'($urandom_range(2048)) * wk_span / 1024 - wk_span / 2;
		b.sim_time = int'(t);
		b.slip_rate = int'(rate_tol) + int'($urandom_range(200)) - 100;
		b.normal_traction = $urandom_range(99) < 10 ? int'($urandom_range(65536))
			: -int'($urandom_range(1 << 20));
		return b;
	endfunction

	task automatic set_phase_regs(int ph);
		bit [31:0] v [7];
		case (ph)
			0: v = '{39322, 32768, 65536, 0, 0, 65536, 0};
			1: v = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
				32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
			2: v = '{0, 32'h7fffffff, 0, 32'h80000000, 0, 0, 0};
			default: v = '{$urandom_range(1 << 18), $urandom_range(1 << 18),
				$urandom_range(1 << 19, 1), $urandom - 32'h80000000 >> ($urandom_range(31)),
				$urandom_range(1 << 20), $urandom_range(1 << 19, 1), $urandom_range(1 << 12)};
		endcase
		write_reg(CFG_COEF_STATIC, v[0]);
		write_reg(CFG_COEF_DYNAMIC, v[1]);
		write_reg(CFG_WEAKENING_SLIP, v[2]);
		write_reg(CFG_COHESION, v[3]);
		write_reg(CFG_WEAKENING_START, v[4]);
		write_reg(CFG_WEAKENING_SPAN, v[5]);
		write_reg(CFG_RATE_TOLERANCE, v[6]);
	endtask

	row_t dir_rows [13] = '{
		'{'{0, 0, 0, 0, 0, -65536}, 1, '{39322, 0, 0}},
		'{'{1, 1, 0, 1000, 5, 1}, 1, '{0, 0, 0}},
		'{'{0, 1, 0, 0, 0, 32'h7fffffff}, 1, '{0, 0, 0}},
		'{'{0, 4, 0, 0, 0, 0}, 1, '{0, 0, 0}},
		'{'{0, 2, 32'h7fffffff, 0, 0, 32'h80000000}, 1, '{1073741824, 0, 0}},
		'{'{1, 3, -65536, 16384, 100, -65536}, 0, '{0, 0, 0}},
		'{'{1, 3, -65536, 32768, 100, -65536}, 0, '{0, 0, 0}},
		'{'{1, 3, -65536, 40000, 0, -65536}, 0, '{0, 0, 0}},
		'{'{0, 3, 16384, 32'h80000000, 0, -131072}, 0, '{0, 0, 0}},
		'{'{1, 1023, 32'h80000000, 32'h7fffffff, 32'h80000000, -1}, 0, '{0, 0, 0}},
		'{'{1, 1023, 0, 32'h80000000, 32'h7fffffff, -65536}, 0, '{0, 0, 0}},
		'{'{0, 1023, 32768, 0, 0, 32'h80000000}, 0, '{0, 0, 0}},
		'{'{1, 5, 32768, 20000, 1, -300000}, 0, '{0, 0, 0}}
	};

	always @(posedge clk) begin
		out_stall <= $urandom_range(99) < stall_pct;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		friction_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected beat", friction, 0);
			end else begin
				want = pending_q.pop_front();
				if (friction !== want.friction)
					report_mismatch("friction", friction, want.friction);
				if (friction_slope !== want.slope)
					report_mismatch("friction_slope", friction_slope, want.slope);
				if (saturated !== want.sat)
					report_mismatch("saturated", saturated, want.sat);
			end
		end
	end

	initial begin
		foreach (cum_store[i]) begin
			cum_store[i] = '0;
			prev_store[i] = 0;
		end
		foreach (last_slip[i]) last_slip[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		send_idle_pct = 9;
		stall_pct = 47;
		@(posedge clk);
		foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].res);
		for (int ph = 0; ph < PHASES; ph++) begin
			in_valid <= 0;
			while (pending_q.size() != 0) @(posedge clk);
			// swap idling sides as the run goes on, then idle neither side
			send_idle_pct = ph < 2 ? 9 : (ph < 4 ? 47 : 0);
			stall_pct = ph < 2 ? 47 : (ph < 4 ? 9 : 0);
			set_phase_regs(ph);
			@(posedge clk);
			for (int n = 0; n < PER_PHASE; n++) send_beat(random_beat(), 0, '0);
		end
		in_valid <= 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
